/* src/jvl_pkg.sv */
// ============================================================================
// jvl_pkg
// Shared types and constants for the joint velocity limiter: the sequencer
// states, the configuration bundle, register indexes and reset values.
// ============================================================================
`default_nettype none

package jvl_pkg;

    // Saturation width of the result and of the stored previous velocity
    localparam int DATA_WIDTH_DEF = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_MAX_VEL   = 3'd0;
    localparam logic [2:0] REG_LOWER     = 3'd1;
    localparam logic [2:0] REG_UPPER     = 3'd2;
    localparam logic [2:0] REG_MARGIN    = 3'd3;
    localparam logic [2:0] REG_MAX_ACCEL = 3'd4;

    // Reset values, Q16.16
    localparam logic [30:0]        RST_MAX_VEL   = 31'd131072;
    localparam logic signed [31:0] RST_LOWER     = -32'sd205887;
    localparam logic signed [31:0] RST_UPPER     = 32'sd205887;
    localparam logic [30:0]        RST_MARGIN    = 31'd6554;
    localparam logic [30:0]        RST_MAX_ACCEL = 31'd655360;

    // Restoring divide: one quotient bit per step
    localparam int DIV_STEPS = 31;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [30:0]        max_velocity;
        logic signed [31:0] lower_limit;
        logic signed [31:0] upper_limit;
        logic [30:0]        limit_margin;
        logic [30:0]        max_acceleration;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_LO_CHK,
        ST_MUL,
        ST_DIV,
        ST_APPLY,
        ST_UP_CHK,
        ST_ACC_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* src/jvl_regs.sv */
// ============================================================================
// jvl_regs
// APB-style register file holding the limiter configuration. Writes land on
// the access cycle; reads return the stored value, zero above its width.
// ============================================================================
`default_nettype none

module jvl_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [jvl_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [jvl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [jvl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready,
    output jvl_pkg::t_cfg                      o_cfg
);

    jvl_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[jvl_pkg::CFG_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_velocity     <= jvl_pkg::RST_MAX_VEL;
            r_cfg.lower_limit      <= jvl_pkg::RST_LOWER;
            r_cfg.upper_limit      <= jvl_pkg::RST_UPPER;
            r_cfg.limit_margin     <= jvl_pkg::RST_MARGIN;
            r_cfg.max_acceleration <= jvl_pkg::RST_MAX_ACCEL;
        end else if (wr_en) begin
            case (reg_idx)
                jvl_pkg::REG_MAX_VEL:   r_cfg.max_velocity     <= pwdata[30:0];
                jvl_pkg::REG_LOWER:     r_cfg.lower_limit      <= signed'(pwdata);
                jvl_pkg::REG_UPPER:     r_cfg.upper_limit      <= signed'(pwdata);
                jvl_pkg::REG_MARGIN:    r_cfg.limit_margin     <= pwdata[30:0];
                jvl_pkg::REG_MAX_ACCEL: r_cfg.max_acceleration <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            jvl_pkg::REG_MAX_VEL:   prdata = {1'b0, r_cfg.max_velocity};
            jvl_pkg::REG_LOWER:     prdata = r_cfg.lower_limit;
            jvl_pkg::REG_UPPER:     prdata = r_cfg.upper_limit;
            jvl_pkg::REG_MARGIN:    prdata = {1'b0, r_cfg.limit_margin};
            jvl_pkg::REG_MAX_ACCEL: prdata = {1'b0, r_cfg.max_acceleration};
            default:                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/joint_velocity_limiter.sv */
// ============================================================================
// joint_velocity_limiter
// Velocity limiter for one joint: clamp, position-limit scaling near both
// limits, then an acceleration bound against the previous result.
// ============================================================================
//
//  channel   direction  payload
//  s_axis    in         tdata: joint_position, raw_velocity, time_step
//  m_axis    out        tdata: limited_velocity; tuser: limit_active
//  apb       in/out     five 32-bit config registers at 0x00..0x10
//
//  Each word passes the clamp, lower-limit check, upper-limit check, accel
//  multiply, accel bound and final state; a limit scaling adds a multiply,
//  a 31-step restoring divide and a sign step. At most one limit scales a
//  given command, since lower-limit scaling leaves it at or below zero.
//  One 31x31 multiplier serves the scale product and the accel bound; one 32-bit subtractor serves every divide step.
//  Synchronous active-low reset restores the register defaults and clears
//  the stored velocity; the first word after reset skips the accel bound.
//  A new word is taken once the previous result sits in the output register;
//  a stalled result stream holds the block in its final state.
// ============================================================================
`default_nettype none

module joint_velocity_limiter #(
    parameter int DATA_WIDTH = jvl_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] joint_position, [63:32] raw_velocity, [80:64] time_step
    input  wire logic [87:0]                   s_axis_tdata,
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [31:0] limited_velocity
    output logic [31:0]                        m_axis_tdata,
    // [0] limit_active
    output logic [0:0]                         m_axis_tuser,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [jvl_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [jvl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [jvl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready
);

    // stored velocity never leaves the 32-bit range, nor the saturation range
    localparam int PREV_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic signed [33:0] SAT_HI = 34'((64'sd1 <<< (PREV_W - 1)) - 64'sd1);
    localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

    jvl_pkg::t_cfg  cfg;
    jvl_pkg::t_state r_state, n_state;

    // word and working registers
    logic signed [31:0]       r_q;
    logic signed [31:0]       r_v;
    logic [16:0]              r_dt;
    logic                     r_active;
    logic                     r_side;
    logic                     r_neg;
    logic [30:0]              r_mag;
    logic [30:0]              r_dist;
    logic [30:0]              r_rem;
    logic [30:0]              r_quo;
    logic [jvl_pkg::CNT_W-1:0] r_cnt;
    logic [31:0]              r_md;
    logic signed [PREV_W-1:0] r_res;
    logic signed [PREV_W-1:0] r_prev;
    logic                     r_first;
    logic                     r_out_valid;
    logic [31:0]              r_out_data;
    logic                     r_out_active;

    // control
    logic out_load;
    logic mul_acc;

    // datapath nets
    logic signed [33:0] q34, v34, raw34, mv34, mg34, lo34, up34;
    logic signed [31:0] v_clamped;
    logic signed [33:0] lo_dist, up_dist;
    logic               lo_hit, up_hit;
    logic [30:0]        v_mag;
    logic [30:0]        mul_a, mul_b;
    logic [61:0]        mul_p;
    logic [32:0]        trial;
    logic [31:0]        rem_sh;
    logic               q_bit;
    logic signed [33:0] prev34, md34, delta, acc_v, sat_v;

    jvl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // operand extension to a common 34-bit signed range
    assign q34  = 34'(r_q);
    assign v34  = 34'(r_v);
    assign raw34 = 34'(signed'(s_axis_tdata[63:32]));
    assign mv34 = signed'({3'b000, cfg.max_velocity});
    assign mg34 = signed'({3'b000, cfg.limit_margin});
    assign lo34 = 34'(cfg.lower_limit);
    assign up34 = 34'(cfg.upper_limit);

    // clamp applied to the latched command
    always_comb begin
        if (v34 > mv34) begin
            v_clamped = 32'(mv34);
        end else if (v34 < -mv34) begin
            v_clamped = 32'(-mv34);
        end else begin
            v_clamped = r_v;
        end
    end

    // limit zone checks
    assign lo_dist = q34 - lo34;
    assign up_dist = up34 - q34;
    assign lo_hit  = (q34 <= lo34 + mg34) && r_v[31];
    assign up_hit  = (q34 >= up34 - mg34) && !r_v[31] && (r_v != '0);
    assign v_mag   = r_v[31] ? 31'(-v34) : r_v[30:0];

    // shared multiplier: scale product or acceleration bound
    assign mul_a = mul_acc ? cfg.max_acceleration : r_mag;
    assign mul_b = mul_acc ? {14'd0, r_dt} : r_dist;
    assign mul_p = {31'd0, mul_a} * {31'd0, mul_b};

    // restoring divide step
    assign rem_sh = {r_rem, r_quo[30]};
    assign trial  = {1'b0, rem_sh} - {2'b00, cfg.limit_margin};
    assign q_bit  = !trial[32];

    // acceleration bound and saturation
    assign prev34 = 34'(r_prev);
    assign md34   = signed'({2'b00, r_md});
    assign delta  = v34 - prev34;
    always_comb begin
        if (!r_first && (delta > md34)) begin
            acc_v = prev34 + md34;
        end else if (!r_first && (delta < -md34)) begin
            acc_v = prev34 - md34;
        end else begin
            acc_v = v34;
        end
        if (acc_v > SAT_HI) begin
            sat_v = SAT_HI;
        end else if (acc_v < SAT_LO) begin
            sat_v = SAT_LO;
        end else begin
            sat_v = acc_v;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jvl_pkg::ST_IDLE: begin
                if (s_axis_tvalid) n_state = jvl_pkg::ST_CLAMP;
            end
            jvl_pkg::ST_CLAMP:  n_state = jvl_pkg::ST_LO_CHK;
            jvl_pkg::ST_LO_CHK: begin
                if (lo_hit && (lo_dist > 0)) begin
                    n_state = jvl_pkg::ST_MUL;
                end else begin
                    n_state = jvl_pkg::ST_UP_CHK;
                end
            end
            jvl_pkg::ST_MUL: n_state = jvl_pkg::ST_DIV;
            jvl_pkg::ST_DIV: begin
                if (r_cnt == '0) n_state = jvl_pkg::ST_APPLY;
            end
            jvl_pkg::ST_APPLY: begin
                n_state = r_side ? jvl_pkg::ST_ACC_MUL : jvl_pkg::ST_UP_CHK;
            end
            jvl_pkg::ST_UP_CHK: begin
                if (up_hit && (up_dist > 0)) begin
                    n_state = jvl_pkg::ST_MUL;
                end else begin
                    n_state = jvl_pkg::ST_ACC_MUL;
                end
            end
            jvl_pkg::ST_ACC_MUL: n_state = jvl_pkg::ST_ACC;
            jvl_pkg::ST_ACC:     n_state = jvl_pkg::ST_DONE;
            jvl_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) n_state = jvl_pkg::ST_IDLE;
            end
            default: n_state = jvl_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = (r_state == jvl_pkg::ST_IDLE);
        out_load      = (r_state == jvl_pkg::ST_DONE) && (!r_out_valid || m_axis_tready);
        mul_acc       = (r_state == jvl_pkg::ST_ACC_MUL);
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jvl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_first     <= 1'b1;
            r_prev      <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_prev      <= r_res;
                r_first     <= 1'b0;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            jvl_pkg::ST_IDLE: begin
                r_q      <= signed'(s_axis_tdata[31:0]);
                r_v      <= 32'(raw34);
                r_dt     <= s_axis_tdata[80:64];
                r_active <= 1'b0;
            end
            jvl_pkg::ST_CLAMP: r_v <= v_clamped;
            jvl_pkg::ST_LO_CHK: begin
                if (lo_hit) begin
                    r_active <= 1'b1;
                    if (lo_dist <= 0) r_v <= '0;
                end
                r_side <= 1'b0;
                r_neg  <= r_v[31];
                r_mag  <= v_mag;
                r_dist <= lo_dist[30:0];
            end
            jvl_pkg::ST_UP_CHK: begin
                if (up_hit) begin
                    r_active <= 1'b1;
                    if (up_dist <= 0) r_v <= '0;
                end
                r_side <= 1'b1;
                r_neg  <= r_v[31];
                r_mag  <= v_mag;
                r_dist <= up_dist[30:0];
            end
            jvl_pkg::ST_MUL: begin
                // product < margin * 2^31, so the top half starts below margin
                r_rem <= mul_p[61:31];
                r_quo <= mul_p[30:0];
                r_cnt <= jvl_pkg::CNT_W'(jvl_pkg::DIV_STEPS - 1);
            end
            jvl_pkg::ST_DIV: begin
                r_rem <= q_bit ? trial[30:0] : rem_sh[30:0];
                r_quo <= {r_quo[29:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
            end
            jvl_pkg::ST_APPLY: begin
                r_v <= r_neg ? -signed'({1'b0, r_quo}) : signed'({1'b0, r_quo});
            end
            jvl_pkg::ST_ACC_MUL: r_md  <= mul_p[47:16];
            jvl_pkg::ST_ACC:     r_res <= sat_v[PREV_W-1:0];
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data   <= 32'(r_res);
            r_out_active <= r_active;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_active;

`ifndef SYNTH
    // an accepted word always starts at the clamp step
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state == jvl_pkg::ST_CLAMP)
        else $error("accepted word did not enter clamp step");

    // partial remainder stays below the margin through the divide
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == jvl_pkg::ST_DIV |-> r_rem < cfg.limit_margin)
        else $error("divide remainder out of range");

    // scaling never grows the command
    a_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == jvl_pkg::ST_APPLY |-> r_quo <= r_mag)
        else $error("scaled magnitude exceeds input magnitude");

    // a new result appears only out of the final state
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == jvl_pkg::ST_DONE)
        else $error("result word loaded outside final state");
`endif

endmodule

`default_nettype wire

/* verif/jvl_result_check.sv */
`timescale 1ns / 100ps
// ============================================================================
// jvl_result_check
// Watches the word streams and the register port of the joint velocity
// limiter, predicts each limited velocity and compares it with the result.
// ============================================================================

module jvl_result_check (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input stream
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    // [31:0] joint_position, [63:32] raw_velocity, [80:64] time_step
    input  wire logic [87:0]                    i_in_data,
    // result stream
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    // [31:0] limited_velocity
    input  wire logic [31:0]                    i_out_data,
    // [0] limit_active
    input  wire logic [0:0]                     i_out_user,
    // register port
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic                           i_pready,
    input  wire logic [jvl_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  wire logic [jvl_pkg::CFG_DATA_W-1:0] i_pwdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam longint VEL_MAX = (longint'(1) << (jvl_pkg::DATA_WIDTH_DEF - 1)) - 1;
    localparam longint VEL_MIN = -VEL_MAX - 1;

    typedef struct {
        logic signed [31:0] velocity;
        logic               limit_hit;
    } t_command;

    t_command       expected_cmds[$];
    jvl_pkg::t_cfg  limits_cfg;
    longint         last_velocity;
    logic           first_tick;
    int             fails = 0;
    int             pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        fails++;
    endtask

    // v * span / margin, truncated toward zero, sign kept
    function automatic longint scale_toward_limit(longint vel, longint span, longint margin);
        longint unsigned mag;
        longint unsigned quo;
        mag = (vel < 0) ? -vel : vel;
        quo = (mag * span) / margin;
        return (vel < 0) ? -$signed(quo) : $signed(quo);
    endfunction

    // Full limiter chain for one accepted word; updates the stored velocity
    function automatic t_command limit_command(logic [87:0] word);
        longint pos, vel, dt, vmax, lo, hi, mg, bound, span;
        t_command cmd;
        pos  = longint'($signed(word[31:0]));
        vel  = longint'($signed(word[63:32]));
        dt   = longint'(word[80:64]);
        vmax = longint'(limits_cfg.max_velocity);
        lo   = longint'($signed(limits_cfg.lower_limit));
        hi   = longint'($signed(limits_cfg.upper_limit));
        mg   = longint'(limits_cfg.limit_margin);
        cmd.limit_hit = 1'b0;

        // clamp to the velocity bound
        if (vel > vmax)
            vel = vmax;
        else if (vel < -vmax)
            vel = -vmax;

        // lower limit zone, moving down
        if (pos <= lo + mg && vel < 0) begin
            span = pos - lo;
            cmd.limit_hit = 1'b1;
            vel = (span <= 0) ? 0 : scale_toward_limit(vel, span, mg);
        end

        // upper limit zone, moving up
        if (pos >= hi - mg && vel > 0) begin
            span = hi - pos;
            cmd.limit_hit = 1'b1;
            vel = (span <= 0) ? 0 : scale_toward_limit(vel, span, mg);
        end

        // acceleration bound, skipped on the first word after reset
        if (first_tick) begin
            first_tick = 1'b0;
        end else begin
            bound = (longint'(limits_cfg.max_acceleration) * dt) >>> 16;
            if (vel - last_velocity > bound)
                vel = last_velocity + bound;
            else if (vel - last_velocity < -bound)
                vel = last_velocity - bound;
        end

        if (vel > VEL_MAX)
            vel = VEL_MAX;
        else if (vel < VEL_MIN)
            vel = VEL_MIN;
        last_velocity = vel;
        cmd.velocity  = vel[31:0];
        return cmd;
    endfunction

    always @(posedge i_clk) begin
        t_command want;
        if (!i_rst_n) begin
            limits_cfg = '{jvl_pkg::RST_MAX_VEL, jvl_pkg::RST_LOWER, jvl_pkg::RST_UPPER,
                           jvl_pkg::RST_MARGIN, jvl_pkg::RST_MAX_ACCEL};
            last_velocity = 0;
            first_tick    = 1'b1;
            expected_cmds.delete();
        end else begin
            // register mirror
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    jvl_pkg::REG_MAX_VEL:   limits_cfg.max_velocity     = i_pwdata[30:0];
                    jvl_pkg::REG_LOWER:     limits_cfg.lower_limit      = i_pwdata;
                    jvl_pkg::REG_UPPER:     limits_cfg.upper_limit      = i_pwdata;
                    jvl_pkg::REG_MARGIN:    limits_cfg.limit_margin     = i_pwdata[30:0];
                    jvl_pkg::REG_MAX_ACCEL: limits_cfg.max_acceleration = i_pwdata[30:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready)
                expected_cmds.push_back(limit_command(i_in_data));

            // compare against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch("unexpected result word", $signed(i_out_data), 0);
                end else begin
                    want = expected_cmds.pop_front();
                    if (i_out_data !== want.velocity)
                        report_mismatch("limited_velocity", $signed(i_out_data),
                                        want.velocity);
                    if (i_out_user[0] !== want.limit_hit)
                        report_mismatch("limit_active", i_out_user[0], want.limit_hit);
                end
            end
        end
        pending = expected_cmds.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Stimulus for the joint velocity limiter: directed words at the limits and
// special cases, then random phases under several register settings, with
// random gaps on both streams. The result checker gives the failure count.
// ============================================================================

module tb_top;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // [31:0] joint_position, [63:32] raw_velocity, [80:64] time_step
    logic [87:0]                    s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [31:0] limited_velocity
    logic [31:0]                    m_axis_tdata;
    // [0] limit_active
    logic [0:0]                     m_axis_tuser;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [jvl_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [jvl_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [jvl_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    int fail_count;
    int pending_words;

    // Current settings, used only to aim stimulus at the limit zones
    logic [30:0]        aim_vmax   = jvl_pkg::RST_MAX_VEL;
    logic signed [31:0] aim_lower  = jvl_pkg::RST_LOWER;
    logic signed [31:0] aim_upper  = jvl_pkg::RST_UPPER;
    logic [30:0]        aim_margin = jvl_pkg::RST_MARGIN;

    // Runs with no idling on either side
    logic quiet_in  = 1'b0;
    logic quiet_out = 1'b0;

    localparam int LO = -205887;
    localparam int HI = 205887;
    localparam int MG = 6554;

    joint_velocity_limiter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    jvl_result_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Setup then access phase; called at a falling edge
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_settings(logic [31:0] vmax, logic [31:0] lower,
                                  logic [31:0] upper, logic [31:0] margin,
                                  logic [31:0] accel);
        write_reg(jvl_pkg::REG_MAX_VEL, vmax);
        write_reg(jvl_pkg::REG_LOWER, lower);
        write_reg(jvl_pkg::REG_UPPER, upper);
        write_reg(jvl_pkg::REG_MARGIN, margin);
        write_reg(jvl_pkg::REG_MAX_ACCEL, accel);
        aim_vmax   = vmax[30:0];
        aim_lower  = lower;
        aim_upper  = upper;
        aim_margin = margin[30:0];
    endtask

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(logic [31:0] pos, logic [31:0] vel, logic [16:0] dt);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 39) == 0)
            quiet_in = !quiet_in;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {7'b0, dt, vel, pos};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random word, mostly aimed at the clamp and the limit zones
    task automatic send_random_word();
        longint      pos, vel, off;
        logic [16:0] dt;
        off = longint'($urandom_range(0, {1'b0, aim_margin} + 32'd16));
        if ($urandom_range(0, 1))
            off = -off;
        case ($urandom_range(0, 9))
            0, 1:    pos = longint'($signed($urandom()));
            2, 3:    pos = longint'(aim_lower) + off;
            4, 5:    pos = longint'(aim_upper) + off;
            6: begin
                case ($urandom_range(0, 5))
                    0:       pos = longint'(aim_lower);
                    1:       pos = longint'(aim_upper);
                    2:       pos = longint'(aim_lower) + aim_margin;
                    3:       pos = longint'(aim_upper) - aim_margin;
                    4:       pos = longint'(aim_lower) - 1;
                    default: pos = longint'(aim_upper) + 1;
                endcase
            end
            7:       pos = longint'($signed($urandom())) >>> 12;
            8:       pos = $urandom_range(0, 1) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
            default: pos = longint'(aim_lower) + off / 2;
        endcase

        case ($urandom_range(0, 9))
            0, 1, 2: vel = longint'($signed($urandom()));
            3, 4, 5: vel = longint'($urandom_range(0, {aim_vmax, 1'b1}));
            6:       vel = longint'(aim_vmax);
            7: begin
                case ($urandom_range(0, 2))
                    0:       vel = 64'sh7FFF_FFFF;
                    1:       vel = -64'sh8000_0000;
                    default: vel = 0;
                endcase
            end
            default: vel = longint'($signed($urandom())) >>> $urandom_range(8, 31);
        endcase
        if ($urandom_range(0, 1))
            vel = -vel;

        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: dt = 17'($urandom_range(0, 65536));
            6: begin
                case ($urandom_range(0, 2))
                    0:       dt = 17'd0;
                    1:       dt = 17'd1;
                    default: dt = 17'd65536;
                endcase
            end
            7:       dt = 17'($urandom_range(65537, 131071));
            default: dt = 17'($urandom_range(0, 2000));
        endcase

        send_word(pos[31:0], vel[31:0], dt);
    endtask

    // Drop valid, wait for every result, then let the block settle
    task automatic wait_idle(int settle);
        s_axis_tvalid = 1'b0;
        while (pending_words != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // Result side: random stall before each word
    initial begin
        int stall;
        @(negedge i_clk);
        forever begin
            stall = quiet_out ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 39) == 0)
                quiet_out = !quiet_out;
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        int          words;
        logic [31:0] vmax, lower, upper, margin, accel;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words at the reset settings
        send_word(32'd0, 32'h7FFF_FFFF, 17'd65536);     // first word: clamp, no accel bound
        send_word(32'd0, 32'h8000_0000, 17'd65536);     // clamp to -max
        send_word(LO, -65536, 17'd65536);               // at lower limit: zero
        send_word(LO - 1, -1, 17'd65536);               // past lower limit
        send_word(LO + MG, -131072, 17'd65536);         // zone edge, full scale
        send_word(LO + 100, -131072, 17'd65536);        // scaled
        send_word(LO + 1, -1, 17'd65536);               // scaling truncates to zero
        send_word(LO, 65536, 17'd65536);                // moving away from lower
        send_word(HI, 65536, 17'd65536);                // at upper limit: zero
        send_word(HI - 3000, 131072, 17'd65536);        // scaled near upper
        send_word(HI + 5, -65536, 17'd65536);           // moving away from upper
        send_word(HI - MG, 131072, 17'd65536);          // upper zone edge
        send_word(32'd0, -131072, 17'd0);               // zero step: held
        send_word(32'd0, 131072, 17'd1);                // tiny accel bound
        send_word(32'd0, -131072, 17'h1FFFF);           // step above one second
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd65536);
        send_word(32'h8000_0000, 32'h8000_0000, 17'd65536);
        send_word(32'd0, 32'd0, 17'd0);
        wait_idle(4);

        // Zero margin with crossed limits
        apply_settings(32'h7FFF_FFFF, 32'd65536, -32'sd65536, 32'd0, 32'h7FFF_FFFF);
        send_word(32'd65536, -65536, 17'd65536);
        send_word(-65536, 65536, 17'd65536);
        send_word(32'd0, -1, 17'd65536);
        send_word(32'd0, 1, 17'd65536);
        send_word(32'd200000, -5, 17'd65536);

        // Random phases
        for (int ph = 0; ph < 9; ph++) begin
            wait_idle(4);
            case (ph)
                0: begin                // widest settings
                    vmax = 32'h7FFF_FFFF;  lower = 32'h8000_0000; upper = 32'h7FFF_FFFF;
                    margin = 32'h7FFF_FFFF; accel = 32'h7FFF_FFFF; words = 240;
                end
                1: begin                // everything zero
                    vmax = '0; lower = '0; upper = '0; margin = '0; accel = '0; words = 60;
                end
                2: begin                // crossed limits with a live zone
                    lower  = $urandom_range(1, 1 << 24);
                    upper  = -$signed(lower);
                    vmax   = $urandom_range(0, 1 << 22);
                    margin = $urandom_range(1, 1 << 25);
                    accel  = $urandom();
                    words  = 200;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       vmax = $urandom();
                        1:       vmax = $urandom_range(0, 1 << 20);
                        2:       vmax = $urandom_range(1 << 16, 1 << 22);
                        default: vmax = 32'hFFFF_FFFF;
                    endcase
                    if ($urandom_range(0, 4) == 0) begin
                        lower = $urandom();
                        upper = $urandom();
                    end else begin
                        lower = -$signed($urandom_range(0, 1 << 24));
                        upper = $urandom_range(0, 1 << 24);
                    end
                    case ($urandom_range(0, 3))
                        0:       margin = '0;
                        1:       margin = $urandom_range(1, 1 << 16);
                        2:       margin = $urandom_range(1, 1 << 22);
                        default: margin = $urandom();
                    endcase
                    case ($urandom_range(0, 3))
                        0:       accel = '0;
                        1:       accel = $urandom();
                        2:       accel = $urandom_range(0, 1 << 22);
                        default: accel = 32'hFFFF_FFFF;
                    endcase
                    words = 240;
                end
            endcase
            apply_settings(vmax, lower, upper, margin, accel);
            repeat (words) send_random_word();
        end

        wait_idle(100);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
